// ===== rtl/amm_pkg.sv =====
// Shared types and constants for the audio matrix mixer.
// Used by the controller, the datapath and the top level; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package amm_pkg;

    // Fixed field widths of the stream payloads.
    localparam int SAMPLE_BITS    = 24;
    localparam int GAIN_BITS      = 20;
    localparam int GAIN_FRAC_BITS = 16;
    localparam int ACC_BITS       = 48;
    localparam int PROD_BITS      = GAIN_BITS + SAMPLE_BITS;
    localparam int CH_BITS        = 4;
    localparam int CH_LIMIT       = 1 << CH_BITS;
    localparam int CFG_BITS       = 5;
    localparam int CFG_ADDR_BITS  = 2;

    // Stream data widths, padded to whole bytes.
    localparam int S_TDATA_BITS = 56;
    localparam int M_TDATA_BITS = 32;

    // Item kinds carried on s_tuser.
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_BITS-1:0] CFG_ENABLE         = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_ACTIVE_INPUTS  = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_ACTIVE_OUTPUTS = 2'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_DIRECT_OUTPUTS = 2'd3;

    typedef struct packed {
        logic                enable;
        logic [CFG_BITS-1:0] active_inputs;
        logic [CFG_BITS-1:0] active_outputs;
        logic [CFG_BITS-1:0] direct_outputs;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_we;       // write zero into the gain store during the clearing pass
        logic load_we;      // write the incoming gain into the store
        logic capture;      // latch the incoming sample and its channel
        logic mac_issue;    // start one multiply-accumulate for one output row
        logic emit_load;    // load one result into the output register
        logic emit_direct;  // the result carries the mix rather than silence
        logic emit_last;    // last result of the frame; also clears the sums
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mac_busy;     // products still in flight toward the accumulators
        logic out_free;     // output register can take a result this cycle
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/amm_ctrl.sv =====
// Sequencer of the audio matrix mixer: clearing pass, row iteration and result emission.
// Depends on amm_pkg; drives the datapath in amm_dp through commands.
`timescale 1ns / 1ps
`default_nettype none

module amm_ctrl #(
    parameter int MAX_INPUTS  = 16,
    parameter int MAX_OUTPUTS = 16
) (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         s_tvalid,
    output logic                        s_tready,
    input  wire                         s_tlast,
    input  wire                         s_mode,
    input  wire  [amm_pkg::CH_BITS-1:0] s_oc,
    input  wire  [amm_pkg::CH_BITS-1:0] s_ic,
    input  amm_pkg::cfg_t               cfg,
    input  amm_pkg::status_t            status,
    output amm_pkg::cmd_t               cmd,
    output logic [amm_dp_aw(MAX_INPUTS, MAX_OUTPUTS)-1:0] clr_addr,
    output logic [amm_rw(MAX_OUTPUTS)-1:0]                mac_row,
    output logic [$clog2(MAX_OUTPUTS + 1)-1:0]            emit_idx
);

    function automatic int amm_rw(input int n);
        int lim;
        lim = (n < amm_pkg::CH_LIMIT) ? n : amm_pkg::CH_LIMIT;
        return (lim > 1) ? $clog2(lim) : 1;
    endfunction

    function automatic int amm_dp_aw(input int ni, input int no);
        return amm_rw(ni) + amm_rw(no);
    endfunction

    localparam int NROW  = (MAX_OUTPUTS < amm_pkg::CH_LIMIT) ? MAX_OUTPUTS : amm_pkg::CH_LIMIT;
    localparam int RW    = amm_rw(MAX_OUTPUTS);
    localparam int AW    = amm_dp_aw(MAX_INPUTS, MAX_OUTPUTS);
    localparam int CNT_W = $clog2(MAX_OUTPUTS + 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MAC   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [AW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [RW-1:0]    row_reg, row_next;
    logic [CNT_W-1:0] out_cnt_reg, out_cnt_next;
    logic             fend_reg, fend_next;

    logic             accept;
    logic             oc_ok, ic_ok, ic_active;
    logic [CNT_W-1:0] nout;
    logic             emit_is_last;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign oc_ok     = int'(s_oc) < MAX_OUTPUTS;
    assign ic_ok     = int'(s_ic) < MAX_INPUTS;
    assign ic_active = {1'b0, s_ic} < cfg.active_inputs;

    // Results per frame: zero acts as one, the count is capped at the output count.
    always_comb begin
        if (cfg.active_outputs == '0) begin
            nout = CNT_W'(1);
        end else if (int'(cfg.active_outputs) > MAX_OUTPUTS) begin
            nout = CNT_W'(MAX_OUTPUTS);
        end else begin
            nout = CNT_W'(cfg.active_outputs);
        end
    end

    assign emit_is_last = (out_cnt_reg + CNT_W'(1)) == nout;

    assign clr_addr = clr_cnt_reg;
    assign mac_row  = row_reg;
    assign emit_idx = out_cnt_reg;

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        row_next     = row_reg;
        out_cnt_next = out_cnt_reg;
        fend_next    = fend_reg;
        cmd          = '0;

        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_we   = 1'b1;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (s_mode == amm_pkg::MODE_LOAD) begin
                        cmd.load_we = oc_ok && ic_ok;
                    end else if (cfg.enable) begin
                        cmd.capture = 1'b1;
                        fend_next   = s_tlast;
                        if (ic_ok && ic_active) begin
                            row_next   = '0;
                            state_next = ST_MAC;
                        end else if (s_tlast) begin
                            out_cnt_next = '0;
                            state_next   = ST_EMIT;
                        end
                    end
                end
            end
            ST_MAC: begin
                cmd.mac_issue = 1'b1;
                row_next      = row_reg + RW'(1);
                if (row_reg == RW'(NROW - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!status.mac_busy) begin
                    out_cnt_next = '0;
                    state_next   = fend_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit_load   = 1'b1;
                    cmd.emit_direct = (int'(out_cnt_reg) < int'(cfg.direct_outputs))
                                      && (int'(out_cnt_reg) < NROW);
                    cmd.emit_last   = emit_is_last;
                    out_cnt_next    = out_cnt_reg + CNT_W'(1);
                    if (emit_is_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            row_reg     <= '0;
            out_cnt_reg <= '0;
            fend_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            row_reg     <= row_next;
            out_cnt_reg <= out_cnt_next;
            fend_reg    <= fend_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/amm_dp.sv =====
// Datapath of the audio matrix mixer: gain store, multiplier, accumulators, output register.
// Depends on amm_pkg; driven by the commands of amm_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module amm_dp #(
    parameter int MAX_INPUTS  = 16,
    parameter int MAX_OUTPUTS = 16
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  amm_pkg::cmd_t                   cmd,
    input  wire  [amm_rw(MAX_INPUTS) + amm_rw(MAX_OUTPUTS)-1:0] clr_addr,
    input  wire  [amm_rw(MAX_OUTPUTS)-1:0]  mac_row,
    input  wire  [$clog2(MAX_OUTPUTS + 1)-1:0] emit_idx,
    input  wire  [amm_pkg::CH_BITS-1:0]     s_oc,
    input  wire  [amm_pkg::CH_BITS-1:0]     s_ic,
    input  wire  [amm_pkg::GAIN_BITS-1:0]   s_gain,
    input  wire  [amm_pkg::SAMPLE_BITS-1:0] s_sample,
    output amm_pkg::status_t                status,
    input  wire                             m_tready,
    output logic                            m_valid,
    output logic [amm_pkg::CH_BITS-1:0]     m_index,
    output logic [amm_pkg::SAMPLE_BITS-1:0] m_mixed,
    output logic                            m_clipped,
    output logic                            m_last
);

    function automatic int amm_rw(input int n);
        int lim;
        lim = (n < amm_pkg::CH_LIMIT) ? n : amm_pkg::CH_LIMIT;
        return (lim > 1) ? $clog2(lim) : 1;
    endfunction

    localparam int RW        = amm_rw(MAX_OUTPUTS);
    localparam int CW        = amm_rw(MAX_INPUTS);
    localparam int AW        = RW + CW;
    localparam int MEM_DEPTH = 1 << AW;
    localparam int ACC_DEPTH = 1 << RW;
    localparam int CNT_W     = $clog2(MAX_OUTPUTS + 1);
    localparam int ACC_W     = amm_pkg::ACC_BITS;
    localparam int SHIFT_W   = amm_pkg::ACC_BITS - amm_pkg::GAIN_FRAC_BITS;
    localparam int SMP_W     = amm_pkg::SAMPLE_BITS;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [SMP_W-1:0] SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
    localparam logic [SMP_W-1:0] SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};

    // Gain store and its single write port.
    logic [amm_pkg::GAIN_BITS-1:0] gain_mem [MEM_DEPTH];
    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    logic [amm_pkg::GAIN_BITS-1:0] mem_wdata;
    logic [AW-1:0]                 mem_raddr;

    logic [CW-1:0]                    ic_reg;
    logic signed [SMP_W-1:0]          sample_reg;

    // Pipeline: gain read, product, accumulate.
    logic signed [amm_pkg::GAIN_BITS-1:0] gain_q_reg;
    logic                                 v1_reg, v2_reg;
    logic [RW-1:0]                        row1_reg, row2_reg;
    logic signed [amm_pkg::PROD_BITS-1:0] prod_reg, prod_next;

    logic signed [ACC_W-1:0] acc_reg [ACC_DEPTH];
    logic [ACC_DEPTH-1:0]    acc_valid_reg;
    logic [RW-1:0]           acc_idx;
    logic signed [ACC_W-1:0] acc_val;
    logic signed [ACC_W:0]   sum;
    logic signed [ACC_W-1:0] sum_sat;

    logic [CNT_W+amm_pkg::CH_BITS-1:0] idx_ext;
    logic [SHIFT_W-1:0]                shifted;
    logic                              clip;
    logic [SMP_W-1:0]                  mix_val;

    logic                              m_valid_reg;
    logic [amm_pkg::CH_BITS-1:0]       m_index_reg;
    logic [SMP_W-1:0]                  m_mixed_reg;
    logic                              m_clipped_reg;
    logic                              m_last_reg;

    assign mem_we    = cmd.clr_we || cmd.load_we;
    assign mem_waddr = cmd.clr_we ? clr_addr : {s_oc[RW-1:0], s_ic[CW-1:0]};
    assign mem_wdata = cmd.clr_we ? '0 : s_gain;
    assign mem_raddr = {mac_row, ic_reg};

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            gain_mem[mem_waddr] <= mem_wdata;
        end
        gain_q_reg <= gain_mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            ic_reg     <= s_ic[CW-1:0];
            sample_reg <= s_sample;
        end
    end

    assign prod_next = gain_q_reg * sample_reg;

    always_ff @(posedge aclk) begin
        row1_reg <= mac_row;
        row2_reg <= row1_reg;
        prod_reg <= prod_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.mac_issue;
            v2_reg <= v1_reg;
        end
    end

    // A row whose valid bit is clear holds zero.
    assign acc_idx = cmd.emit_load ? emit_idx[RW-1:0] : row2_reg;
    assign acc_val = acc_valid_reg[acc_idx] ? acc_reg[acc_idx] : '0;

    assign sum = {acc_val[ACC_W-1], acc_val} + (ACC_W+1)'(prod_reg);

    always_comb begin
        if (sum[ACC_W] != sum[ACC_W-1]) begin
            sum_sat = sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            sum_sat = sum[ACC_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (v2_reg) begin
            acc_reg[row2_reg] <= sum_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_valid_reg <= '0;
        end else if (cmd.emit_load && cmd.emit_last) begin
            acc_valid_reg <= '0;
        end else if (v2_reg) begin
            acc_valid_reg[row2_reg] <= 1'b1;
        end
    end

    // Floor shift by the gain fraction, then saturate to the sample width.
    assign shifted = acc_val[ACC_W-1:amm_pkg::GAIN_FRAC_BITS];
    assign clip    = (shifted[SHIFT_W-1:SMP_W-1] != '0) && (shifted[SHIFT_W-1:SMP_W-1] != '1);

    always_comb begin
        if (!cmd.emit_direct) begin
            mix_val = '0;
        end else if (clip) begin
            mix_val = shifted[SHIFT_W-1] ? SMP_MIN : SMP_MAX;
        end else begin
            mix_val = shifted[SMP_W-1:0];
        end
    end

    assign idx_ext = (CNT_W + amm_pkg::CH_BITS)'(emit_idx);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_load) begin
            m_index_reg   <= idx_ext[amm_pkg::CH_BITS-1:0];
            m_mixed_reg   <= mix_val;
            m_clipped_reg <= cmd.emit_direct && clip;
            m_last_reg    <= cmd.emit_last;
        end
    end

    assign status.mac_busy = v1_reg || v2_reg;
    assign status.out_free = !m_valid_reg || m_tready;

    assign m_valid   = m_valid_reg;
    assign m_index   = m_index_reg;
    assign m_mixed   = m_mixed_reg;
    assign m_clipped = m_clipped_reg;
    assign m_last    = m_last_reg;

endmodule

`default_nettype wire

// ===== rtl/audio_matrix_mixer.sv =====
// Top level of the audio matrix mixer: configuration registers and stream ports.
// Depends on amm_pkg, amm_ctrl and amm_dp.
`timescale 1ns / 1ps
`default_nettype none

// The mixer keeps a matrix of signed Q4.16 gains, one per output row and input column.
// Each transaction on the s_ channel is either a gain load (s_tuser = 0), which writes one
// gain into the store, or an audio sample (s_tuser = 1) for one input channel. A sample is
// multiplied by the gains of its column and added into every output accumulator. A sample
// with s_tlast set ends the frame: the block then sends one saturated Q1.23 result per
// active output on the m_ channel, m_tlast marking the last one, and clears the sums.
// Outputs at or above direct_outputs send silence. While enable is low, samples are dropped.
//
// Throughput: a load leaves the block ready for the next transaction. A mixed sample is
// handled by the single multiplier that walks the rows one per cycle followed by its two
// pipeline registers; s_tready stays low until they drain. A frame end then sends one
// result per active output. An ignored channel leaves the block ready at once.
//
// After reset the block clears the gain store, one entry per cycle, all
// 2^(row address bits + column address bits) entries (256 with sixteen rows and columns);
// s_tready stays low meanwhile, while configuration writes are still taken.
// Results sit in an output register. When the receiver stalls, the block keeps taking
// transactions until a frame needs the output register again, and then waits.

module audio_matrix_mixer #(
    parameter int MAX_INPUTS  = 16,
    parameter int MAX_OUTPUTS = 16
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    // Configuration write port.
    input  wire                                   cfg_we,
    input  wire  [amm_pkg::CFG_ADDR_BITS-1:0]     cfg_addr,
    input  wire  [amm_pkg::CFG_BITS-1:0]          cfg_wdata,
    // Input stream.
    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    // s_tdata, lowest bit first: out_channel[3:0], in_channel[7:4], gain[27:8],
    // sample[51:28], zero padding[55:52].
    input  wire  [amm_pkg::S_TDATA_BITS-1:0]      s_tdata,
    // s_tuser: mode[0].
    input  wire  [0:0]                            s_tuser,
    input  wire                                   s_tlast,
    // Result stream.
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    // m_tdata, lowest bit first: out_index[3:0], mixed[27:4], zero padding[31:28].
    output logic [amm_pkg::M_TDATA_BITS-1:0]      m_tdata,
    // m_tuser: clipped[0].
    output logic [0:0]                            m_tuser,
    output logic                                  m_tlast
);

    function automatic int amm_rw(input int n);
        int lim;
        lim = (n < amm_pkg::CH_LIMIT) ? n : amm_pkg::CH_LIMIT;
        return (lim > 1) ? $clog2(lim) : 1;
    endfunction

    localparam int RW    = amm_rw(MAX_OUTPUTS);
    localparam int AW    = amm_rw(MAX_INPUTS) + RW;
    localparam int CNT_W = $clog2(MAX_OUTPUTS + 1);
    localparam int CHB   = amm_pkg::CH_BITS;
    localparam int GB    = amm_pkg::GAIN_BITS;
    localparam int SB    = amm_pkg::SAMPLE_BITS;

    // Configuration registers.
    logic                         enable_reg;
    logic [amm_pkg::CFG_BITS-1:0] active_inputs_reg;
    logic [amm_pkg::CFG_BITS-1:0] active_outputs_reg;
    logic [amm_pkg::CFG_BITS-1:0] direct_outputs_reg;
    amm_pkg::cfg_t                cfg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg         <= 1'b0;
            active_inputs_reg  <= 5'd16;
            active_outputs_reg <= 5'd16;
            direct_outputs_reg <= 5'd16;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                amm_pkg::CFG_ENABLE:         enable_reg         <= cfg_wdata[0];
                amm_pkg::CFG_ACTIVE_INPUTS:  active_inputs_reg  <= cfg_wdata;
                amm_pkg::CFG_ACTIVE_OUTPUTS: active_outputs_reg <= cfg_wdata;
                amm_pkg::CFG_DIRECT_OUTPUTS: direct_outputs_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign cfg.enable         = enable_reg;
    assign cfg.active_inputs  = active_inputs_reg;
    assign cfg.active_outputs = active_outputs_reg;
    assign cfg.direct_outputs = direct_outputs_reg;

    // Unpack the input transaction.
    logic [CHB-1:0] s_oc;
    logic [CHB-1:0] s_ic;
    logic [GB-1:0]  s_gain;
    logic [SB-1:0]  s_sample;

    assign s_oc     = s_tdata[CHB-1:0];
    assign s_ic     = s_tdata[2*CHB-1:CHB];
    assign s_gain   = s_tdata[2*CHB+GB-1:2*CHB];
    assign s_sample = s_tdata[2*CHB+GB+SB-1:2*CHB+GB];

    amm_pkg::cmd_t    cmd;
    amm_pkg::status_t status;
    logic [AW-1:0]    clr_addr;
    logic [RW-1:0]    mac_row;
    logic [CNT_W-1:0] emit_idx;

    amm_ctrl #(
        .MAX_INPUTS  (MAX_INPUTS),
        .MAX_OUTPUTS (MAX_OUTPUTS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .s_mode   (s_tuser[0]),
        .s_oc     (s_oc),
        .s_ic     (s_ic),
        .cfg      (cfg),
        .status   (status),
        .cmd      (cmd),
        .clr_addr (clr_addr),
        .mac_row  (mac_row),
        .emit_idx (emit_idx)
    );

    logic [CHB-1:0] m_index;
    logic [SB-1:0]  m_mixed;
    logic           m_clipped;

    amm_dp #(
        .MAX_INPUTS  (MAX_INPUTS),
        .MAX_OUTPUTS (MAX_OUTPUTS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .clr_addr  (clr_addr),
        .mac_row   (mac_row),
        .emit_idx  (emit_idx),
        .s_oc      (s_oc),
        .s_ic      (s_ic),
        .s_gain    (s_gain),
        .s_sample  (s_sample),
        .status    (status),
        .m_tready  (m_tready),
        .m_valid   (m_tvalid),
        .m_index   (m_index),
        .m_mixed   (m_mixed),
        .m_clipped (m_clipped),
        .m_last    (m_tlast)
    );

    // Pack the result transaction.
    assign m_tdata = amm_pkg::M_TDATA_BITS'({m_mixed, m_index});
    assign m_tuser = m_clipped;

endmodule

`default_nettype wire

// ===== tb/audio_matrix_mixer_checker.sv =====
// Scoreboard for the audio matrix mixer: mirrors the gain matrix and the output sums,
// predicts every result transaction and compares it field by field. Depends on amm_pkg.
`timescale 1ns / 1ps

module audio_matrix_mixer_checker (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   cfg_we,
    input  wire  [amm_pkg::CFG_ADDR_BITS-1:0]     cfg_addr,
    input  wire  [amm_pkg::CFG_BITS-1:0]          cfg_wdata,
    input  wire                                   s_tvalid,
    input  wire                                   s_tready,
    input  wire  [amm_pkg::S_TDATA_BITS-1:0]      s_tdata,
    input  wire  [0:0]                            s_tuser,
    input  wire                                   s_tlast,
    input  wire                                   m_tvalid,
    input  wire                                   m_tready,
    input  wire  [amm_pkg::M_TDATA_BITS-1:0]      m_tdata,
    input  wire  [0:0]                            m_tuser,
    input  wire                                   m_tlast,
    input  wire                                   end_of_run,
    output int                                    fail_count,
    output int                                    pending
);
    import amm_pkg::*;

    localparam longint ACC_TOP       = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_BOTTOM    = -ACC_TOP - 1;
    localparam longint SAMPLE_TOP    = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_BOTTOM = -SAMPLE_TOP - 1;
    // Past this many lines a broken design only floods the log; counting goes on.
    localparam int     PRINT_CAP     = 100;

    typedef struct packed {
        logic [CH_BITS-1:0]     idx;
        logic [SAMPLE_BITS-1:0] mixed;
        logic                   clip;
        logic                   last;
    } mix_result_t;

    logic signed [GAIN_BITS-1:0] gain_matrix [CH_LIMIT][CH_LIMIT];
    longint                      out_sums [CH_LIMIT];
    logic                        en_r;
    logic [CFG_BITS-1:0]         active_in_r;
    logic [CFG_BITS-1:0]         active_out_r;
    logic [CFG_BITS-1:0]         direct_out_r;
    mix_result_t                 mix_results_q [$];
    bit                          leftovers_done;

    initial begin
        fail_count     = 0;
        pending        = 0;
        leftovers_done = 0;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (fail_count < PRINT_CAP)
            $display("%0t checker: %s: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    // Applies one accepted input transaction to the mirrored state and queues the
    // results it causes. Loads act even while disabled; a frame end drains the sums.
    task automatic mix_item(input logic mode, input logic [CH_BITS-1:0] oc,
                            input logic [CH_BITS-1:0] ic,
                            input logic signed [GAIN_BITS-1:0] gain,
                            input logic signed [SAMPLE_BITS-1:0] smp, input logic fend);
        longint      sum;
        longint      lvl;
        int          n_out;
        mix_result_t r;
        if (mode == MODE_LOAD) begin
            gain_matrix[oc][ic] = gain;
            return;
        end
        if (!en_r)
            return;
        if (ic < active_in_r) begin
            for (int o = 0; o < CH_LIMIT; o++) begin
                sum = out_sums[o] + longint'(gain_matrix[o][ic]) * longint'(smp);
                if (sum > ACC_TOP)
                    sum = ACC_TOP;
                if (sum < ACC_BOTTOM)
                    sum = ACC_BOTTOM;
                out_sums[o] = sum;
            end
        end
        if (!fend)
            return;
        if (active_out_r == 0)
            n_out = 1;
        else if (active_out_r > CH_LIMIT)
            n_out = CH_LIMIT;
        else
            n_out = active_out_r;
        for (int o = 0; o < n_out; o++) begin
            lvl    = 0;
            r.clip = 1'b0;
            if (o < direct_out_r) begin
                // Arithmetic shift rounds toward minus infinity.
                lvl = out_sums[o] >>> GAIN_FRAC_BITS;
                if (lvl > SAMPLE_TOP) begin
                    lvl    = SAMPLE_TOP;
                    r.clip = 1'b1;
                end
                if (lvl < SAMPLE_BOTTOM) begin
                    lvl    = SAMPLE_BOTTOM;
                    r.clip = 1'b1;
                end
            end
            r.idx   = o;
            r.mixed = lvl[SAMPLE_BITS-1:0];
            r.last  = (o == n_out - 1);
            mix_results_q.push_back(r);
        end
        for (int o = 0; o < CH_LIMIT; o++)
            out_sums[o] = 0;
    endtask

    always @(posedge aclk) begin : watch
        mix_result_t want;
        if (!aresetn) begin
            en_r         = 1'b0;
            active_in_r  = 5'd16;
            active_out_r = 5'd16;
            direct_out_r = 5'd16;
            for (int o = 0; o < CH_LIMIT; o++) begin
                out_sums[o] = 0;
                for (int i = 0; i < CH_LIMIT; i++)
                    gain_matrix[o][i] = '0;
            end
            mix_results_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_ENABLE:         en_r         = cfg_wdata[0];
                    CFG_ACTIVE_INPUTS:  active_in_r  = cfg_wdata;
                    CFG_ACTIVE_OUTPUTS: active_out_r = cfg_wdata;
                    CFG_DIRECT_OUTPUTS: direct_out_r = cfg_wdata;
                    default: ;
                endcase
            end
            // A result can never stem from an input taken at the same edge, so the
            // result side is checked before new expectations are queued.
            if (m_tvalid && m_tready) begin
                if (mix_results_q.size() == 0) begin
                    report_mismatch("result with nothing expected, index", m_tdata[3:0], -1);
                end else begin
                    want = mix_results_q.pop_front();
                    if (m_tdata[3:0] !== want.idx)
                        report_mismatch("out_index", m_tdata[3:0], want.idx);
                    if (m_tdata[27:4] !== want.mixed)
                        report_mismatch($sformatf("mixed of output %0d", want.idx),
                                        $signed(m_tdata[27:4]), $signed(want.mixed));
                    if (m_tuser[0] !== want.clip)
                        report_mismatch($sformatf("clipped of output %0d", want.idx),
                                        m_tuser[0], want.clip);
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("last_out of output %0d", want.idx),
                                        m_tlast, want.last);
                end
            end
            if (s_tvalid && s_tready)
                mix_item(s_tuser[0], s_tdata[3:0], s_tdata[7:4], s_tdata[27:8],
                         s_tdata[51:28], s_tlast);
            if (end_of_run && !leftovers_done) begin
                leftovers_done = 1;
                while (mix_results_q.size() != 0) begin
                    want = mix_results_q.pop_front();
                    report_mismatch("result never sent, index", -1, want.idx);
                end
            end
        end
        pending = mix_results_q.size();
    end

endmodule

// ===== tb/audio_matrix_mixer_tb.sv =====
// Top of the audio matrix mixer testbench: clock, reset, stimulus, receiver stalls and
// the verdict. Depends on amm_pkg, audio_matrix_mixer and audio_matrix_mixer_checker.
`timescale 1ns / 1ps

module audio_matrix_mixer_tb;
    import amm_pkg::*;

    // The slowest correct run: about 220 items, frames of up to sixteen results each
    // waiting out a receiver that idles 70 percent of the time, the clearing pass after
    // reset and one long receiver hold. The limit sits well above that.
    localparam int CYCLE_LIMIT   = 300_000;
    // Quiet time after the last result before a register write or the verdict, long enough
    // for a mixed sample to leave the multiplier.
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 55;

    localparam logic [GAIN_BITS-1:0]   GAIN_MAX   = 20'h7FFFF;
    localparam logic [GAIN_BITS-1:0]   GAIN_MIN   = 20'h80000;
    localparam logic [GAIN_BITS-1:0]   GAIN_UNITY = 20'h10000;
    localparam logic [GAIN_BITS-1:0]   GAIN_MINUS = 20'hF0000;
    localparam logic [GAIN_BITS-1:0]   GAIN_LSB   = 20'h00001;
    localparam logic [SAMPLE_BITS-1:0] SMP_MAX    = 24'h7FFFFF;
    localparam logic [SAMPLE_BITS-1:0] SMP_MIN    = 24'h800000;
    localparam logic [SAMPLE_BITS-1:0] SMP_M1     = 24'hFFFFFF;

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_we;
    logic [CFG_ADDR_BITS-1:0]  cfg_addr;
    logic [CFG_BITS-1:0]       cfg_wdata;
    logic                      s_tvalid;
    wire                       s_tready;
    logic [S_TDATA_BITS-1:0]   s_tdata;
    logic [0:0]                s_tuser;
    logic                      s_tlast;
    wire                       m_tvalid;
    logic                      m_tready;
    wire  [M_TDATA_BITS-1:0]   m_tdata;
    wire  [0:0]                m_tuser;
    wire                       m_tlast;
    logic                      end_of_run;
    int                        fail_count;
    int                        pending;

    int                        send_idle_pct;
    int                        recv_idle_pct;
    int                        hold_requests;
    int                        items_sent;
    int                        active_in_now;
    int                        cycle_count;

    audio_matrix_mixer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    audio_matrix_mixer_checker scoreboard (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .end_of_run (end_of_run),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the block hangs or drops results.
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side. Stalls follow the current idle percentage, except while a long hold
    // asked for by the stimulus is running; the hold length is counted here, so the
    // sender keeps offering transactions meanwhile and the block backs up.
    initial begin : receiver
        int hold_served;
        int hold_left;
        hold_served = 0;
        hold_left   = 0;
        m_tready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_served != hold_requests) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready = 1'b0;
            end else begin
                m_tready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offers one input transaction, with random gaps ahead of it, and returns at the
    // falling edge after it was taken. tvalid drops there unless the next call raises
    // it again in the same time step.
    task automatic send_item(input logic mode, input logic [CH_BITS-1:0] oc,
                             input logic [CH_BITS-1:0] ic, input logic [GAIN_BITS-1:0] gain,
                             input logic [SAMPLE_BITS-1:0] smp, input logic fend);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {4'b0000, smp, gain, ic, oc};
        s_tuser  = mode;
        s_tlast  = fend;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        items_sent++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx, input int value);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = value;
        if (idx == CFG_ACTIVE_INPUTS)
            active_in_now = value;
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // Waits until every expected result has arrived and the multiplier has run dry.
    task automatic settle();
        while (pending != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // New random register setting: mostly full size, sometimes any value the
    // fields allow, including zero counts and counts beyond sixteen.
    task automatic pick_settings();
        settle();
        write_reg(CFG_ENABLE, 1);
        write_reg(CFG_ACTIVE_INPUTS, ($urandom_range(9) < 7) ? 16 : $urandom_range(31));
        write_reg(CFG_ACTIVE_OUTPUTS, ($urandom_range(1) == 0) ? 16 : $urandom_range(31));
        write_reg(CFG_DIRECT_OUTPUTS, ($urandom_range(1) == 0) ? 16 : $urandom_range(31));
    endtask

    function automatic logic [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(7))
            0:       return SMP_MAX;
            1:       return SMP_MIN;
            default: return $urandom;
        endcase
    endfunction

    initial begin : stimulus
        int                   target;
        int                   half;
        int                   n_items;
        bit                   changed;
        logic [CH_BITS-1:0]   ic;
        logic [GAIN_BITS-1:0] g;

        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = CFG_ENABLE;
        cfg_wdata     = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = MODE_LOAD;
        s_tlast       = 1'b0;
        end_of_run    = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests = 0;
        items_sent    = 0;
        active_in_now = 16;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        // Directed part. The block comes out of reset disabled: loads still land,
        // a sample with frame end is dropped without any result.
        send_item(MODE_LOAD, 4'd0, 4'd0, GAIN_MAX, SMP_MIN, 1'b0);
        send_item(MODE_LOAD, 4'd15, 4'd15, GAIN_MIN, SMP_MAX, 1'b0);
        send_item(MODE_SAMPLE, 4'd0, 4'd0, '0, SMP_MAX, 1'b1);
        settle();
        write_reg(CFG_ENABLE, 1);
        // A load carrying frame end must not end a frame.
        send_item(MODE_LOAD, 4'd1, 4'd0, GAIN_UNITY, '0, 1'b1);
        send_item(MODE_LOAD, 4'd2, 4'd0, GAIN_MINUS, '0, 1'b0);
        send_item(MODE_LOAD, 4'd4, 4'd3, GAIN_LSB, '0, 1'b0);
        // Channel zero twice in one frame adds twice; rows 0, 1, 2 and 15 clip,
        // row 4 sees a tiny negative sum that must floor to minus one.
        send_item(MODE_SAMPLE, 4'd0, 4'd0, '0, SMP_MAX, 1'b0);
        send_item(MODE_SAMPLE, 4'd0, 4'd0, '0, SMP_MAX, 1'b0);
        send_item(MODE_SAMPLE, 4'd0, 4'd15, '0, SMP_MIN, 1'b0);
        send_item(MODE_SAMPLE, 4'd0, 4'd3, '0, SMP_M1, 1'b1);
        // Sums survive a disabled stretch, and the frame end seen then is dropped.
        send_item(MODE_SAMPLE, 4'd0, 4'd0, '0, 24'd1, 1'b0);
        settle();
        write_reg(CFG_ENABLE, 0);
        send_item(MODE_SAMPLE, 4'd0, 4'd0, '0, SMP_MAX, 1'b1);
        settle();
        write_reg(CFG_ENABLE, 1);
        send_item(MODE_SAMPLE, 4'd0, 4'd3, '0, SMP_M1, 1'b1);
        // A zero output count acts as one; channels past the active count still end
        // the frame; with no direct outputs everything is silent.
        settle();
        write_reg(CFG_ACTIVE_INPUTS, 1);
        write_reg(CFG_ACTIVE_OUTPUTS, 0);
        write_reg(CFG_DIRECT_OUTPUTS, 0);
        send_item(MODE_SAMPLE, 4'd0, 4'd5, '0, SMP_MAX, 1'b1);
        send_item(MODE_SAMPLE, 4'd0, 4'd0, '0, SMP_MAX, 1'b1);
        // Counts beyond sixteen act as sixteen.
        settle();
        write_reg(CFG_ACTIVE_INPUTS, 31);
        write_reg(CFG_ACTIVE_OUTPUTS, 31);
        write_reg(CFG_DIRECT_OUTPUTS, 31);
        send_item(MODE_SAMPLE, 4'd0, 4'd15, '0, SMP_MIN, 1'b1);
        settle();
        write_reg(CFG_ACTIVE_OUTPUTS, 1);
        write_reg(CFG_DIRECT_OUTPUTS, 16);
        send_item(MODE_SAMPLE, 4'd0, 4'd0, '0, SMP_MAX, 1'b1);
        settle();
        write_reg(CFG_ACTIVE_INPUTS, 16);
        write_reg(CFG_ACTIVE_OUTPUTS, 16);
        write_reg(CFG_DIRECT_OUTPUTS, 8);
        send_item(MODE_SAMPLE, 4'd0, 4'd0, '0, SMP_MIN, 1'b1);

        // Loud frame: full-scale gains of both signs on one channel, sent often
        // enough that row 7 hits the top of the 48-bit sum and row 8 the bottom.
        settle();
        write_reg(CFG_DIRECT_OUTPUTS, 16);
        send_item(MODE_LOAD, 4'd7, 4'd9, GAIN_MIN, '0, 1'b0);
        send_item(MODE_LOAD, 4'd8, 4'd9, GAIN_MAX, '0, 1'b0);
        for (int k = 0; k < 34; k++)
            send_item(MODE_SAMPLE, 4'd0, 4'd9, '0, SMP_MIN, k == 33);

        // Random part in three idling phases, two register settings per phase. The
        // long receiver hold comes at the start of the phase without gaps.
        for (int ph = 0; ph < 3; ph++) begin
            pick_settings();
            send_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 70 : 0;
            recv_idle_pct = (ph == 0) ? 70 : (ph == 1) ? 36 : 0;
            if (ph == 2)
                hold_requests++;
            target  = items_sent + PHASE_ITEMS;
            half    = items_sent + PHASE_ITEMS / 2;
            changed = 0;
            while (items_sent < target) begin
                // Now and then a few gain loads, with junk in the unused fields.
                if ($urandom_range(1) == 0) begin
                    n_items = $urandom_range(1, 3);
                    for (int k = 0; k < n_items; k++) begin
                        g = $urandom;
                        // Mostly moderate gains so that not every frame clips.
                        if ($urandom_range(3) != 0)
                            g = $signed(g) >>> $urandom_range(2, 8);
                        send_item(MODE_LOAD, $urandom_range(15), $urandom_range(15), g,
                                  $urandom, $urandom_range(1));
                    end
                end
                // One well-formed sample instant: channels mostly below the active
                // count, frame end on the last one.
                n_items = $urandom_range(1, 8);
                for (int k = 0; k < n_items; k++) begin
                    if (active_in_now == 0 || $urandom_range(7) == 0)
                        ic = $urandom_range(15);
                    else
                        ic = $urandom_range(((active_in_now > 16) ? 16 : active_in_now) - 1);
                    send_item(MODE_SAMPLE, $urandom_range(15), ic, $urandom, rand_sample(),
                              k == n_items - 1);
                end
                // Occasional stray sample that may or may not close a frame.
                if ($urandom_range(9) == 0)
                    send_item(MODE_SAMPLE, $urandom_range(15), $urandom_range(15), $urandom,
                              rand_sample(), $urandom_range(1));
                if (!changed && items_sent >= half) begin
                    changed = 1;
                    pick_settings();
                end
            end
        end

        // A stray sample without frame end may have left sums behind; close the
        // frame so nothing is still in flight, then drain and check.
        send_item(MODE_SAMPLE, 4'd0, 4'd0, '0, '0, 1'b1);
        settle();
        end_of_run = 1'b1;
        @(negedge aclk);
        @(negedge aclk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
